// File: src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_SIZE_LOG2 = 6;
	localparam int OWNER_BITS    = 8;
	localparam int NODE_COUNT    = (2 << MAX_SIZE_LOG2) - 1;
	localparam int IDX_W         = MAX_SIZE_LOG2 + 1;
	localparam int LVL_W         = $clog2(MAX_SIZE_LOG2 + 1);
	localparam int SZ_W          = MAX_SIZE_LOG2 + 2;

	localparam logic [1:0] KIND_ABSENT = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_ALLOC  = 2'd2;
	localparam logic [1:0] KIND_SPLIT  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NO_OWNER = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] owner_id;
		logic [6:0] request_size;
	} bba_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] block_offset;
		logic [2:0] block_size_log2;
	} bba_rsp_t;

endpackage

// File: src/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a block tree in RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  req     | req_valid, req_ready, req        | in
//  rsp     | rsp_valid, rsp_ready, rsp        | out
//  cfg     | cfg_we, cfg_wdata                | in
//
// Each tree node visited costs a RAM read and a decide step, plus a state per climb
// step or extra tree write; a zero-size allocate is answered from idle, a grant at
// the root after one read and decide, and a free over a fully split tree walks the
// tree twice, once to find the block and once from the root to merge.
// Reset and a cfg write clear the per-node valid bits at once: one free root.
// The result waits in an output register; a new request is taken once it leaves.
module buddy_block_allocator
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bba_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output bba_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_SPL  = 3'd3;
	localparam logic [2:0] S_BK   = 3'd4;
	localparam logic [2:0] S_MD   = 3'd5;

	localparam logic [1:0] M_ALLOC = 2'd0;
	localparam logic [1:0] M_FIND  = 2'd1;
	localparam logic [1:0] M_MERGE = 2'd2;

	logic [2:0]            state_q;
	logic [1:0]            mode_q;
	logic [LVL_W-1:0]      msl_q;
	logic [IDX_W-1:0]      idx_q;
	logic [LVL_W-1:0]      lvl_q;
	logic [1:0]            kind_q;
	logic                  kv_q;
	logic [NODE_COUNT-1:0] valid_q;
	logic [(1<<LVL_W)-1:0] flag_q;
	logic [OWNER_BITS-1:0] id_q;
	logic [6:0]            size_q;
	bba_rsp_t              res_q;
	bba_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	logic                  kwe;
	logic [IDX_W-1:0]      kwaddr;
	logic [1:0]            kwdata;
	logic                  owe;
	logic [1:0]            krd;
	logic [OWNER_BITS-1:0] ord;
	logic [1:0]            kread;
	logic [LVL_W-1:0]      sl;
	logic [SZ_W-1:0]       pow;
	logic                  fit_full;
	logic                  fit_half;
	logic [IDX_W-1:0]      pos;
	logic [IDX_W-1:0]      off;
	logic [IDX_W-1:0]      child;
	logic [IDX_W-1:0]      parent;
	logic                  absent;
	logic                  accept;
	logic [LVL_W-1:0]      cfg_sat;
	bba_rsp_t              hit;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an unwritten root reads as one free block
	assign kread    = kv_q ? krd : ((idx_q == '0) ? KIND_FREE : KIND_ABSENT);
	assign sl       = msl_q - lvl_q;
	assign pow      = SZ_W'(1) << sl;
	assign fit_full = pow >= SZ_W'(size_q);
	assign fit_half = (sl != '0) && ((pow >> 1) >= SZ_W'(size_q));
	assign pos      = idx_q - ((IDX_W'(1) << lvl_q) - IDX_W'(1));
	assign off      = pos << sl;
	assign child    = {idx_q[IDX_W-2:0], 1'b1};
	assign parent   = (idx_q - IDX_W'(1)) >> 1;
	assign absent   = (kind_q == KIND_FREE) || (kind_q == KIND_ABSENT);

	always_comb begin
		hit.status          = ST_OK;
		hit.block_offset    = off[5:0];
		hit.block_size_log2 = 3'(sl);
	end

	always_comb begin
		cfg_sat = LVL_W'(cfg_wdata);
		if (cfg_wdata == 3'd0) begin
			cfg_sat = LVL_W'(1);
		end else if (32'(cfg_wdata) > MAX_SIZE_LOG2) begin
			cfg_sat = LVL_W'(MAX_SIZE_LOG2);
		end
	end

	// tree writes: at most one kind write per cycle
	always_comb begin
		kwe    = 1'b0;
		kwaddr = idx_q;
		kwdata = KIND_FREE;
		owe    = 1'b0;
		case (state_q)
			S_DEC: begin
				case (mode_q)
					M_ALLOC: begin
						if (kread == KIND_ABSENT) begin
							kwe = 1'b1;
						end else if (kread != KIND_ALLOC && !fit_half
								&& kread == KIND_FREE && fit_full) begin
							kwe    = 1'b1;
							kwdata = KIND_ALLOC;
							owe    = 1'b1;
						end
					end
					M_FIND: begin
						if (kread == KIND_ALLOC && id_q == ord) begin
							kwe = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SPL: begin
				kwe    = 1'b1;
				kwaddr = parent;
				kwdata = KIND_SPLIT;
			end
			S_MD: begin
				if (idx_q != '0 && kind_q == KIND_FREE) begin
					kwe    = 1'b1;
					kwdata = KIND_ABSENT;
				end else if (idx_q != '0 && !idx_q[0] && flag_q[lvl_q] && absent) begin
					kwe    = 1'b1;
					kwaddr = parent;
				end
			end
			default: ;
		endcase
	end

	bba_ram #(.WIDTH(2), .DEPTH(1 << IDX_W)) u_kind_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (kwaddr),
		.wdata (kwdata),
		.raddr (idx_q),
		.rdata (krd)
	);

	bba_ram #(.WIDTH(OWNER_BITS), .DEPTH(1 << IDX_W)) u_owner_ram (
		.clk   (clk),
		.we    (owe),
		.waddr (idx_q),
		.wdata (id_q),
		.raddr (idx_q),
		.rdata (ord)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_ALLOC;
			msl_q       <= LVL_W'(MAX_SIZE_LOG2);
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			lvl_q       <= '0;
			kv_q        <= 1'b0;
			flag_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (kwe) begin
				valid_q[kwaddr[IDX_W-1:0]] <= 1'b1;
			end
			if (cfg_we) begin
				msl_q   <= cfg_sat;
				valid_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						lvl_q  <= '0;
						mode_q <= (req.op == OP_FREE) ? M_FIND : M_ALLOC;
						if (req.op == OP_ALLOC && req.request_size == 7'd0) begin
							rsp_q       <= '{ST_NO_FIT, 6'd0, 3'd0};
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					kv_q    <= valid_q[idx_q];
					state_q <= S_DEC;
				end
				S_DEC: begin
					kind_q <= kread;
					case (mode_q)
						M_ALLOC: begin
							if (kread == KIND_ABSENT) begin
								// create the child, then mark its parent split
								kind_q  <= KIND_FREE;
								state_q <= S_SPL;
							end else if (kread == KIND_ALLOC) begin
								state_q <= S_BK;
							end else if (fit_half) begin
								idx_q   <= child;
								lvl_q   <= lvl_q + LVL_W'(1);
								state_q <= S_RD;
							end else if (kread == KIND_FREE && fit_full) begin
								rsp_q       <= hit;
								rsp_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end else begin
								state_q <= S_BK;
							end
						end
						M_FIND: begin
							if (kread == KIND_ALLOC && id_q == ord) begin
								res_q   <= hit;
								idx_q   <= '0;
								lvl_q   <= '0;
								mode_q  <= M_MERGE;
								state_q <= S_RD;
							end else if (kread != KIND_SPLIT || lvl_q >= msl_q) begin
								state_q <= S_BK;
							end else begin
								idx_q   <= child;
								lvl_q   <= lvl_q + LVL_W'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							if (kread == KIND_SPLIT && lvl_q < msl_q) begin
								idx_q   <= child;
								lvl_q   <= lvl_q + LVL_W'(1);
								state_q <= S_RD;
							end else begin
								state_q <= S_MD;
							end
						end
					endcase
				end
				S_SPL: begin
					// the new child now reads back as written
					kind_q  <= KIND_FREE;
					kv_q    <= 1'b1;
					state_q <= S_DEC;
				end
				S_BK: begin
					if (idx_q == '0) begin
						rsp_q.status          <= (mode_q == M_FIND) ? ST_NO_OWNER : ST_NO_FIT;
						rsp_q.block_offset    <= 6'd0;
						rsp_q.block_size_log2 <= 3'd0;
						rsp_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end else if (idx_q[0]) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RD;
					end else begin
						idx_q <= parent;
						lvl_q <= lvl_q - LVL_W'(1);
					end
				end
				S_MD: begin
					if (idx_q == '0) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (kind_q == KIND_FREE) begin
						kind_q <= KIND_ABSENT;
					end else if (idx_q[0]) begin
						flag_q[lvl_q] <= absent;
						idx_q         <= idx_q + IDX_W'(1);
						state_q       <= S_RD;
					end else begin
						// right buddy done: climb to parent, merging into it if both buddies are empty
						kind_q <= (flag_q[lvl_q] && absent) ? KIND_FREE : KIND_SPLIT;
						idx_q  <= parent;
						lvl_q  <= lvl_q - LVL_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold request fields for the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= req.owner_id[OWNER_BITS-1:0];
			size_q <= req.request_size;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> lvl_q <= msl_q)
		else $error("walk level beyond tree depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !req_ready)
		else $error("request taken while result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE || rsp_valid_q)
		else $error("request dropped without walk or result");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> !kwe)
		else $error("tree write during read cycle");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the buddy block allocator against a block-tree predictor: directed
// corner cases, then random allocate/free traffic at several memory sizes,
// with random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import bba_pkg::*;

	class alloc_scoreboard;
		logic [1:0] kind[NODE_COUNT];
		logic [7:0] owner[NODE_COUNT];
		int         mem_log2;
		bba_rsp_t   expected_rsp[$];
		int         errors;
		int         granted;
		int         released;

		function void clear_tree();
			foreach (kind[i]) kind[i] = KIND_ABSENT;
			kind[0] = KIND_FREE;
		endfunction

		function void configure(logic [2:0] v);
			int s;
			s = v;
			if (s < 1) s = 1;
			if (s > MAX_SIZE_LOG2) s = MAX_SIZE_LOG2;
			mem_log2 = s;
			clear_tree();
		endfunction

		function bit place(int idx, int lvl, int need, logic [7:0] id,
			output int gidx, output int glvl);
			int sl;
			sl = mem_log2 - lvl;
			if (kind[idx] == KIND_ALLOC || kind[idx] == KIND_ABSENT) return 0;
			if (sl >= 1 && (1 << (sl - 1)) >= need) begin
				for (int c = 2 * idx + 1; c <= 2 * idx + 2; c++) begin
					if (kind[c] == KIND_ABSENT) begin
						kind[c]   = KIND_FREE;
						kind[idx] = KIND_SPLIT;
						return place(c, lvl + 1, need, id, gidx, glvl);
					end
					if (place(c, lvl + 1, need, id, gidx, glvl)) return 1;
				end
				return 0;
			end
			if (kind[idx] == KIND_FREE && (1 << sl) >= need) begin
				kind[idx]  = KIND_ALLOC;
				owner[idx] = id;
				gidx = idx;
				glvl = lvl;
				return 1;
			end
			return 0;
		endfunction

		function int find_block(int idx, int lvl, logic [7:0] id, output int flvl);
			int r;
			if (kind[idx] == KIND_ALLOC && owner[idx] == id) begin
				flvl = lvl;
				return idx;
			end
			if (kind[idx] != KIND_SPLIT || lvl >= mem_log2) return -1;
			r = find_block(2 * idx + 1, lvl + 1, id, flvl);
			if (r >= 0) return r;
			return find_block(2 * idx + 2, lvl + 1, id, flvl);
		endfunction

		function void coalesce(int idx, int lvl);
			if (kind[idx] != KIND_SPLIT || lvl >= mem_log2) return;
			for (int c = 2 * idx + 1; c <= 2 * idx + 2; c++) begin
				coalesce(c, lvl + 1);
				if (kind[c] == KIND_FREE) kind[c] = KIND_ABSENT;
			end
			if (kind[2 * idx + 1] == KIND_ABSENT && kind[2 * idx + 2] == KIND_ABSENT)
				kind[idx] = KIND_FREE;
		endfunction

		function void note_input(bba_req_t r);
			bba_rsp_t e;
			int idx, lvl;
			e = '0;
			e.status = ST_NO_FIT;
			idx = 0;
			lvl = 0;
			if (r.op == OP_ALLOC) begin
				if (r.request_size != 0 &&
					place(0, 0, int'(r.request_size), r.owner_id, idx, lvl)) begin
					e.status = ST_OK;
					granted++;
				end
			end else begin
				idx = find_block(0, 0, r.owner_id, lvl);
				if (idx < 0) begin
					e.status = ST_NO_OWNER;
				end else begin
					e.status = ST_OK;
					kind[idx] = KIND_FREE;
					coalesce(0, 0);
					released++;
				end
			end
			if (e.status == ST_OK) begin
				e.block_offset    = 6'((idx - ((1 << lvl) - 1)) << (mem_log2 - lvl));
				e.block_size_log2 = 3'(mem_log2 - lvl);
			end
			expected_rsp.push_back(e);
		endfunction

		function void check_result(bba_rsp_t a);
			bba_rsp_t e;
			if (expected_rsp.size() == 0) begin
				$error("unexpected result transfer %p", a);
				errors++;
				return;
			end
			e = expected_rsp.pop_front();
			if (a.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, a.status);
				errors++;
			end
			if (a.block_offset !== e.block_offset) begin
				$error("block_offset expected %0d actual %0d", e.block_offset, a.block_offset);
				errors++;
			end
			if (a.block_size_log2 !== e.block_size_log2) begin
				$error("block_size_log2 expected %0d actual %0d",
					e.block_size_log2, a.block_size_log2);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	bba_req_t   req;
	logic       rsp_valid;
	logic       rsp_ready;
	bba_rsp_t   rsp;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	alloc_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;
	int  hold_left;
	int  items_sent;
	int  cfg_writes;

	buddy_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#20ms;
		$display("buddy_block_allocator: mismatch");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) sb.note_input(req);
			if (rsp_valid && rsp_ready) sb.check_result(rsp);
		end
	end

	task automatic send_item(logic op, logic [7:0] id, logic [6:0] units);
		bba_req_t r;
		r.op           = op;
		r.owner_id     = id;
		r.request_size = units;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && req_ready));
		items_sent++;
	endtask

	// drop valid and wait until every transfer has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(logic [2:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(v);
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic random_traffic(int count);
		logic [7:0] id;
		logic [6:0] units;
		int cap;
		for (int n = 0; n < count; n++) begin
			cap = 1 << sb.mem_log2;
			id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
			case ($urandom_range(0, 9))
				0: units = 7'($urandom);
				1, 2: units = 7'($urandom_range(1, cap));
				default: units = 7'($urandom_range(1, (cap > 4) ? cap / 4 : cap));
			endcase
			send_item(($urandom_range(0, 99) < 40) ? OP_FREE : OP_ALLOC, id, units);
		end
	endtask

	initial begin
		logic [2:0] sizes[8];
		sizes = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4, 3'd6};
		sb = new();
		sb.configure(3'd6);
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		hold_req  = 0;
		hold_left = 0;
		send_idle_pct = 11;
		recv_idle_pct = 68;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at full size
		send_item(OP_ALLOC, 8'd1, 7'd0);
		send_item(OP_ALLOC, 8'd1, 7'd65);
		send_item(OP_ALLOC, 8'd1, 7'd127);
		send_item(OP_ALLOC, 8'd1, 7'd64);
		send_item(OP_ALLOC, 8'd2, 7'd1);
		send_item(OP_FREE,  8'd1, 7'd0);
		send_item(OP_FREE,  8'd1, 7'd0);
		send_item(OP_ALLOC, 8'd255, 7'd1);
		send_item(OP_ALLOC, 8'd0, 7'd33);
		send_item(OP_ALLOC, 8'd3, 7'd32);
		send_item(OP_ALLOC, 8'd4, 7'd2);
		send_item(OP_ALLOC, 8'd5, 7'd16);
		send_item(OP_ALLOC, 8'd6, 7'd3);
		send_item(OP_FREE,  8'd0, 7'd127);
		send_item(OP_FREE,  8'd255, 7'd0);
		send_item(OP_FREE,  8'd99, 7'd0);
		send_item(OP_FREE,  8'd4, 7'd0);
		send_item(OP_FREE,  8'd5, 7'd0);
		send_item(OP_FREE,  8'd6, 7'd0);
		send_item(OP_ALLOC, 8'd7, 7'd32);
		send_item(OP_FREE,  8'd7, 7'd0);
		send_item(OP_FREE,  8'd3, 7'd0);

		// fill the output register and stall the input for a while
		hold_req = 1;
		random_traffic(40);
		random_traffic(60);
		drain();

		foreach (sizes[i]) begin
			if (i == 3) begin
				send_idle_pct = 68;
				recv_idle_pct = 11;
			end else if (i == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_size(sizes[i]);
			random_traffic(95);
			drain();
		end

		repeat (50) @(posedge clk);
		$display("run covered %0d requests over %0d size settings", items_sent, cfg_writes + 1);
		$display("%0d blocks granted, %0d blocks released", sb.granted, sb.released);
		if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
			$display("buddy_block_allocator: match");
		end else begin
			$display("buddy_block_allocator: mismatch");
		end
		$finish;
	end
endmodule
